### hdl/itoa_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
`timescale 1ns / 1ps
package itoa_pkg;

  // Format request codes
  localparam logic [1:0] MODE_SDEC    = 2'd0;
  localparam logic [1:0] MODE_UDEC    = 2'd1;
  localparam logic [1:0] MODE_HEX     = 2'd2;
  localparam logic [1:0] MODE_HEX_ALT = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_LOW = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int VALUE_W       = 64;
  localparam int NUM_DIGITS    = 20;
  localparam int DIGIT_W       = 4;
  localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
  localparam int FIELD_W       = 6;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SPACE,
    BK_SIGN,
    BK_PFX0,
    BK_PFXX,
    BK_ZERO,
    BK_DIGIT
  } back_state_e;

  // One classified number, ready for emission
  typedef struct packed {
    logic [BCD_W-1:0]     digits;
    logic [DIG_IDX_W-1:0] top_digit;
    logic                 neg;
    logic                 hex;
    logic                 zpad;
    logic [FIELD_W-1:0]   pad;
  } fmt_t;

endpackage

### hdl/itoa_front.sv
// Front end: accepts items, works out sign, magnitude and digits, and queues them.
`timescale 1ns / 1ps
module itoa_front #(
  parameter int MAX_FIELD_WIDTH = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic                          is_long_i,
  input  logic [itoa_pkg::VALUE_W-1:0]  value_i,
  input  logic [itoa_pkg::FIELD_W-1:0]  width_i,
  input  logic                          zero_pad_i,
  output logic                          push_o,
  output itoa_pkg::fmt_t                push_data_o,
  input  logic                          full_i
);

  localparam int VW = itoa_pkg::VALUE_W;
  localparam int BW = itoa_pkg::BCD_W;
  localparam int DW = itoa_pkg::DIGIT_W;
  localparam int FW = itoa_pkg::FIELD_W;

  itoa_pkg::front_state_e state_q, state_d;

  logic [VW-1:0]                bin_q, bin_d;
  logic [BW-1:0]                bcd_q, bcd_d;
  logic [itoa_pkg::STEP_W-1:0]  step_q;
  logic                         hex_q, neg_q, zpad_q;
  logic [FW-1:0]                wsat_q;

  logic                         accept;
  logic                         hex_in, neg_in;
  logic [VW-1:0]                mag_in;
  logic [FW-1:0]                wsat_in;
  logic [itoa_pkg::DIG_IDX_W-1:0] top;
  logic [FW:0]                  text_len;

  assign accept = in_valid_i && !in_stall_o;

  // Classify the incoming item
  always_comb begin
    hex_in  = (mode_i == itoa_pkg::MODE_HEX) || (mode_i == itoa_pkg::MODE_HEX_ALT);
    wsat_in = (width_i > FW'(MAX_FIELD_WIDTH)) ? FW'(MAX_FIELD_WIDTH) : width_i;
    if (is_long_i) begin
      neg_in = (mode_i == itoa_pkg::MODE_SDEC) && value_i[VW-1];
      mag_in = neg_in ? (VW'(0) - value_i) : value_i;
    end else begin
      neg_in = (mode_i == itoa_pkg::MODE_SDEC) && value_i[VW/2-1];
      mag_in = {{(VW/2){1'b0}},
                (neg_in ? ((VW/2)'(0) - value_i[VW/2-1:0]) : value_i[VW/2-1:0])};
    end
  end

  // Shift-add-3 binary to BCD, a few bits per cycle
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    for (int k = 0; k < itoa_pkg::BITS_PER_STEP; k++) begin
      for (int j = 0; j < itoa_pkg::NUM_DIGITS; j++) begin
        if (bcd_d[j*DW +: DW] >= DW'(5)) begin
          bcd_d[j*DW +: DW] = bcd_d[j*DW +: DW] + DW'(3);
        end
      end
      bcd_d = {bcd_d[BW-2:0], bin_d[VW-1]};
      bin_d = {bin_d[VW-2:0], 1'b0};
    end
  end

  // Highest non-zero digit and padding length
  always_comb begin
    top = '0;
    for (int j = 0; j < itoa_pkg::NUM_DIGITS; j++) begin
      if (bcd_q[j*DW +: DW] != '0) begin
        top = itoa_pkg::DIG_IDX_W'(j);
      end
    end
    text_len = (FW+1)'(top) + (FW+1)'(1) +
               (hex_q ? (FW+1)'(2) : (neg_q ? (FW+1)'(1) : (FW+1)'(0)));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::FR_IDLE: begin
        if (in_valid_i) begin
          state_d = hex_in ? itoa_pkg::FR_PUSH : itoa_pkg::FR_CONV;
        end
      end
      itoa_pkg::FR_CONV: begin
        if (step_q == itoa_pkg::STEP_W'(itoa_pkg::CONV_STEPS - 1)) begin
          state_d = itoa_pkg::FR_PUSH;
        end
      end
      itoa_pkg::FR_PUSH: begin
        if (!full_i) begin
          state_d = itoa_pkg::FR_IDLE;
        end
      end
      default: state_d = itoa_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o            = (state_q != itoa_pkg::FR_IDLE);
    push_o                = (state_q == itoa_pkg::FR_PUSH) && !full_i;
    push_data_o.digits    = bcd_q;
    push_data_o.top_digit = top;
    push_data_o.neg       = neg_q;
    push_data_o.hex       = hex_q;
    push_data_o.zpad      = zpad_q;
    push_data_o.pad       = ({1'b0, wsat_q} > text_len) ?
                            FW'({1'b0, wsat_q} - text_len) : FW'(0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == itoa_pkg::FR_CONV) begin
        step_q <= step_q + itoa_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hex_q  <= hex_in;
      neg_q  <= neg_in;
      zpad_q <= zero_pad_i;
      wsat_q <= wsat_in;
      bin_q  <= mag_in;
      // Hex digits are the magnitude's nibbles as they stand
      bcd_q  <= hex_in ? {{(BW-VW){1'b0}}, mag_in} : '0;
    end else if (state_q == itoa_pkg::FR_CONV) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

endmodule

### hdl/itoa_fifo.sv
// Short queue of classified numbers between front end and emitter.
`timescale 1ns / 1ps
module itoa_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itoa_pkg::fmt_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output itoa_pkg::fmt_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itoa_pkg::fmt_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hdl/itoa_back.sv
// Emitter: walks padding, sign, prefix, digits; one char per cycle unless stalled.
`timescale 1ns / 1ps
module itoa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  itoa_pkg::fmt_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     character_o,
  output logic           last_o
);

  localparam int FW = itoa_pkg::FIELD_W;
  localparam int IW = itoa_pkg::DIG_IDX_W;
  localparam int DW = itoa_pkg::DIGIT_W;

  itoa_pkg::back_state_e state_q, state_d;
  itoa_pkg::fmt_t        entry_q;
  logic [FW-1:0]         cnt_q;
  logic [IW-1:0]         dig_q;
  logic                  out_valid_q, last_q;
  logic [7:0]            char_q;

  logic                  advance, emit;
  logic                  head_space, head_zero, entry_zero;
  logic [DW-1:0]         digit;
  logic [7:0]            char_c;
  logic                  last_c;

  // First phase that applies, given which of sign, prefix and zero padding remain
  function automatic itoa_pkg::back_state_e phase_after(input logic neg,
                                                        input logic hex,
                                                        input logic zero);
    if (neg) begin
      phase_after = itoa_pkg::BK_SIGN;
    end else if (hex) begin
      phase_after = itoa_pkg::BK_PFX0;
    end else if (zero) begin
      phase_after = itoa_pkg::BK_ZERO;
    end else begin
      phase_after = itoa_pkg::BK_DIGIT;
    end
  endfunction

  assign advance    = !out_valid_q || !out_stall_i;
  assign head_space = !head_i.zpad && (head_i.pad != '0);
  assign head_zero  = head_i.zpad && (head_i.pad != '0);
  assign entry_zero = entry_q.zpad && (entry_q.pad != '0);
  assign digit      = entry_q.digits[{dig_q, 2'b00} +: DW];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = head_space ? itoa_pkg::BK_SPACE
                               : phase_after(head_i.neg, head_i.hex, head_zero);
        end
      end
      itoa_pkg::BK_SPACE: begin
        if (advance && cnt_q == FW'(1)) begin
          state_d = phase_after(entry_q.neg, entry_q.hex, 1'b0);
        end
      end
      itoa_pkg::BK_SIGN: begin
        if (advance) begin
          state_d = phase_after(1'b0, entry_q.hex, entry_zero);
        end
      end
      itoa_pkg::BK_PFX0: begin
        if (advance) begin
          state_d = itoa_pkg::BK_PFXX;
        end
      end
      itoa_pkg::BK_PFXX: begin
        if (advance) begin
          state_d = phase_after(1'b0, 1'b0, entry_zero);
        end
      end
      itoa_pkg::BK_ZERO: begin
        if (advance && cnt_q == FW'(1)) begin
          state_d = itoa_pkg::BK_DIGIT;
        end
      end
      itoa_pkg::BK_DIGIT: begin
        if (advance && dig_q == '0) begin
          state_d = itoa_pkg::BK_IDLE;
        end
      end
      default: state_d = itoa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == itoa_pkg::BK_IDLE) && !empty_i;
    emit   = (state_q != itoa_pkg::BK_IDLE) && advance;
    last_c = 1'b0;
    unique case (state_q)
      itoa_pkg::BK_SPACE: char_c = itoa_pkg::CH_SPACE;
      itoa_pkg::BK_SIGN:  char_c = itoa_pkg::CH_MINUS;
      itoa_pkg::BK_PFX0:  char_c = itoa_pkg::CH_ZERO;
      itoa_pkg::BK_PFXX:  char_c = itoa_pkg::CH_X;
      itoa_pkg::BK_ZERO:  char_c = itoa_pkg::CH_ZERO;
      itoa_pkg::BK_DIGIT: begin
        char_c = (digit < DW'(10)) ? (itoa_pkg::CH_ZERO + 8'(digit))
                                   : (itoa_pkg::CH_A_LOW + 8'(digit) - 8'd10);
        last_c = (dig_q == '0);
      end
      default: char_c = itoa_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dig_q       <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        cnt_q <= head_i.pad;
        dig_q <= head_i.top_digit;
      end else if (emit) begin
        if (state_q == itoa_pkg::BK_SPACE || state_q == itoa_pkg::BK_ZERO) begin
          cnt_q <= cnt_q - FW'(1);
        end
        if (state_q == itoa_pkg::BK_DIGIT) begin
          dig_q <= dig_q - IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= head_i;
    end
    if (emit) begin
      char_q <= char_c;
      last_q <= last_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

### hdl/integer_to_ascii_padded_top.sv
// Top level of the integer to ASCII formatter with field width padding.
//
//   channel  direction  handshake                payload
//   input    in         in_valid_i / in_stall_o  mode_i, is_long_i, value_i, width_i,
//                                                zero_pad_i
//   output   out        out_valid_o / out_stall_i character_o, last_o
//
// For a decimal item the front end runs 16 shift-add-3 steps of four bits each
// between accept and queue write; a hex item goes straight to the queue write.
// The emitter sends one character per cycle while the output is not stalled, and
// loads each item from the queue in its idle state. The front end takes no new
// item until the last is queued, yet converts one while the emitter sends others.
// Reset is asynchronous and empties the queue; no clearing pass is needed.
// A stall on the output freezes only the emitter; the front end runs ahead
// until the queue is full.
`timescale 1ns / 1ps
module integer_to_ascii_padded_top #(
  parameter int MAX_FIELD_WIDTH = 63,
  parameter int QUEUE_DEPTH     = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic                          is_long_i,
  input  logic [itoa_pkg::VALUE_W-1:0]  value_i,
  input  logic [itoa_pkg::FIELD_W-1:0]  width_i,
  input  logic                          zero_pad_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    character_o,
  output logic                          last_o
);

  logic           q_push, q_full, q_pop, q_empty;
  itoa_pkg::fmt_t q_in, q_head;

  itoa_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .is_long_i   (is_long_i),
    .value_i     (value_i),
    .width_i     (width_i),
    .zero_pad_i  (zero_pad_i),
    .push_o      (q_push),
    .push_data_o (q_in),
    .full_i      (q_full)
  );

  itoa_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      ((character_o >= itoa_pkg::CH_ZERO && character_o <= 8'h39) ||
       (character_o >= itoa_pkg::CH_A_LOW && character_o <= 8'h66)))
    else $error("final character of a number is not a digit");

endmodule
